>>> design/bsp_pkg.sv
// Shared types, codes and sizes of the batch size padding policy block.
package bsp_pkg;

    localparam int MAX_SIZES = 8;
    localparam int SIZE_BITS = 16;
    localparam int COST_BITS = 32;
    localparam int IDX_W     = (MAX_SIZES > 1) ? $clog2(MAX_SIZES) : 1;
    localparam int PROD_BITS = COST_BITS + SIZE_BITS;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 4;
    localparam int MODE_W    = 2;
    localparam int OUTCOME_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;

    localparam logic [CMD_W-1:0] CMD_DECIDE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_SIZE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_COST = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PAD_UP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BATCH_DOWN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN_COST   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNSUP      = 2'd3;

    localparam logic [OUTCOME_W-1:0] OUT_ACK        = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_KEEP       = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_DOWN       = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_UP_CHEAPER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING_OFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATS_PRESENT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [15:0]        cand_size;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               cost_known;
    } t_in_req;

    typedef struct packed {
        logic [15:0]          chosen_size;
        logic [OUTCOME_W-1:0] outcome;
        logic                 above_largest;
    } t_out_res;

    // Search probe walking the cell row.
    typedef struct packed {
        logic [SIZE_BITS-1:0] cand;
        logic                 up_found;
        logic [SIZE_BITS-1:0] up_size;
        logic [COST_BITS-1:0] up_cost;
        logic                 up_cv;
        logic                 dn_found;
        logic [SIZE_BITS-1:0] dn_size;
        logic [COST_BITS-1:0] dn_cost;
        logic                 dn_cv;
    } t_probe;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_CMP,
        ST_HOLD
    } t_state;

endpackage

>>> design/batch_size_padding_policy.sv
// Top level: config registers, request control, cell row and output register.
//
//  channel | direction | handshake            | payload
//  in      | request   | i_in_valid/o_in_stall | i_in_data  (t_in_req)
//  out     | result    | o_out_valid/i_out_stall | o_out_data (t_out_res)
//  cfg     | write     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A decide request that reaches the table walks the probe through the cell row one
// cell a cycle, then passes the multiply, compare and hold states into the output
// register. Writes and early keeps go from idle straight to the hold state. One
// request is in work at a time.
// Reset is synchronous, active low; it clears control, config and cost valid bits.
// A stalled result waits in the output register while the next request is taken.
module batch_size_padding_policy (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bsp_pkg::t_in_req      i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bsp_pkg::t_out_res     o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [3:0]            i_cfg_data
);
    import bsp_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic               r_padding_off;
    logic [COUNT_W-1:0] r_size_count;
    logic               r_stats;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   n_cnt;
    t_out_res           r_res;
    t_out_res           n_res;
    logic               r_out_valid;
    t_out_res           r_out;

    logic               accept;
    logic               is_decide;
    logic               early_keep;
    logic               shift;
    logic               mul;
    logic               out_free;
    logic               load_out;
    t_probe             probe_in;
    t_probe             chain [MAX_SIZES+1];
    t_out_res           judge_res;

    assign accept     = i_in_valid && !o_in_stall;
    assign is_decide  = (i_in_data.cmd == CMD_DECIDE);
    assign early_keep = (i_in_data.cand_size == '0) || (r_mode == MODE_PAD_UP) ||
                        (r_mode == MODE_UNSUP) || (r_mode == MODE_MIN_COST && !r_stats) ||
                        r_padding_off || (r_size_count == '0);
    assign out_free   = !r_out_valid || !i_out_stall;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PAD_UP;
            r_padding_off <= 1'b0;
            r_size_count  <= '0;
            r_stats       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POLICY_MODE:   r_mode        <= i_cfg_data[MODE_W-1:0];
                REG_PADDING_OFF:   r_padding_off <= i_cfg_data[0];
                REG_SIZE_COUNT:    r_size_count  <= i_cfg_data[COUNT_W-1:0];
                REG_STATS_PRESENT: r_stats       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (is_decide && !early_keep && MAX_SIZES > 1) begin
                        n_state = ST_SCAN;
                    end else if (is_decide && !early_keep) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(MAX_SIZES - 2)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_CMP;
            ST_CMP:  n_state = ST_HOLD;
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        o_in_stall = 1'b1;
        shift      = 1'b0;
        mul        = 1'b0;
        load_out   = 1'b0;
        n_res      = r_res;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                shift      = accept;
                if (accept && !is_decide) begin
                    n_res = '{chosen_size: '0, outcome: OUT_ACK, above_largest: 1'b0};
                end else if (accept) begin
                    n_res = '{chosen_size: i_in_data.cand_size, outcome: OUT_KEEP,
                              above_largest: 1'b0};
                end
            end
            ST_SCAN: shift = 1'b1;
            ST_MUL:  mul = 1'b1;
            ST_CMP:  n_res = judge_res;
            ST_HOLD: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        probe_in          = '0;
        probe_in.cand     = SIZE_BITS'(i_in_data.cand_size);
    end

    assign chain[0] = probe_in;

    for (genvar k = 0; k < MAX_SIZES; k++) begin : g_cell
        logic en;
        logic wr_hit;

        assign en     = (k < int'(r_size_count));
        assign wr_hit = accept && (int'(i_in_data.slot) == k);

        bsp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_wr_size  (wr_hit && i_in_data.cmd == CMD_WRITE_SIZE),
            .i_wr_cost  (wr_hit && i_in_data.cmd == CMD_WRITE_COST),
            .i_wr_data  (i_in_data.value),
            .i_wr_known (i_in_data.cost_known),
            .i_shift    (shift),
            .i_probe    (chain[k]),
            .o_probe    (chain[k+1])
        );
    end

    bsp_judge u_judge (
        .i_clk   (i_clk),
        .i_mul   (mul),
        .i_mode  (r_mode),
        .i_probe (chain[MAX_SIZES]),
        .o_res   (judge_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/bsp_cell.sv
// One table cell: an allowed size, its cost, and one stage of the search probe.
module bsp_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_wr_size,
    input  logic                  i_wr_cost,
    input  logic [31:0]           i_wr_data,
    input  logic                  i_wr_known,
    input  logic                  i_shift,
    input  bsp_pkg::t_probe       i_probe,
    output bsp_pkg::t_probe       o_probe
);
    import bsp_pkg::*;

    logic [SIZE_BITS-1:0] r_size;
    logic [COST_BITS-1:0] r_cost;
    logic                 r_cost_valid;
    t_probe               r_probe;
    t_probe               n_probe;
    logic                 ge;
    logic                 le;

    assign ge = i_en && (r_size >= i_probe.cand);
    assign le = i_en && (r_size <= i_probe.cand);

    // First hit from slot 0 for the up size; last hit wins for the down size.
    always_comb begin
        n_probe = i_probe;
        if (!i_probe.up_found && ge) begin
            n_probe.up_found = 1'b1;
            n_probe.up_size  = r_size;
            n_probe.up_cost  = r_cost;
            n_probe.up_cv    = r_cost_valid;
        end
        if (le) begin
            n_probe.dn_found = 1'b1;
            n_probe.dn_size  = r_size;
            n_probe.dn_cost  = r_cost;
            n_probe.dn_cv    = r_cost_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_size) begin
            r_size <= i_wr_data[SIZE_BITS-1:0];
        end
        if (i_wr_cost) begin
            r_cost <= i_wr_data[COST_BITS-1:0];
        end
        if (i_shift) begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_valid <= 1'b0;
        end else if (i_wr_cost) begin
            r_cost_valid <= i_wr_known;
        end
    end

    assign o_probe = r_probe;

endmodule

>>> design/bsp_judge.sv
// Final decision: cross-multiplied cost compare and outcome selection.
module bsp_judge (
    input  logic                  i_clk,
    input  logic                  i_mul,
    input  logic [1:0]            i_mode,
    input  bsp_pkg::t_probe       i_probe,
    output bsp_pkg::t_out_res     o_res
);
    import bsp_pkg::*;

    logic [PROD_BITS-1:0] r_prod_up;
    logic [PROD_BITS-1:0] r_prod_dn;

    // up_cost / cand < dn_cost / dn_size, cross multiplied
    always_ff @(posedge i_clk) begin
        if (i_mul) begin
            r_prod_up <= PROD_BITS'(i_probe.up_cost) * PROD_BITS'(i_probe.dn_size);
            r_prod_dn <= PROD_BITS'(i_probe.dn_cost) * PROD_BITS'(i_probe.cand);
        end
    end

    always_comb begin
        o_res.chosen_size   = 16'(i_probe.cand);
        o_res.outcome       = OUT_KEEP;
        o_res.above_largest = 1'b0;
        priority if (!i_probe.up_found) begin
            o_res.above_largest = 1'b1;
        end else if (i_probe.up_size == i_probe.cand || !i_probe.dn_found ||
                     i_probe.dn_size == i_probe.cand) begin
            o_res.outcome = OUT_KEEP;
        end else if (i_mode == MODE_MIN_COST && (!i_probe.dn_cv || !i_probe.up_cv)) begin
            o_res.outcome = OUT_KEEP;
        end else if (i_mode == MODE_MIN_COST && r_prod_up < r_prod_dn) begin
            o_res.outcome = OUT_UP_CHEAPER;
        end else begin
            o_res.chosen_size = 16'(i_probe.dn_size);
            o_res.outcome     = OUT_DOWN;
        end
    end

endmodule

>>> design/bsp_chk.sv
// Port-level checks on the batch size padding policy block, bound to the top.
module bsp_chk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  bsp_pkg::t_in_req      i_in_data,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  bsp_pkg::t_out_res     o_out_data
);
    import bsp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.outcome == OUT_ACK) |->
        (o_out_data.chosen_size == '0 && !o_out_data.above_largest))
        else $error("write acknowledgement carries data");

    a_above_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.above_largest) |-> (o_out_data.outcome == OUT_KEEP))
        else $error("above largest without keeping the candidate");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind batch_size_padding_policy bsp_chk u_bsp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> tb/sv/bsp_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class for the batch size padding policy testbench.
package bsp_tb_pkg;

    import bsp_pkg::*;

    // cmd 3 has no name in the design package; the block acks it and changes nothing
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    class policy_checker;
        logic [MODE_W-1:0]    mode;
        logic                 pad_off;
        logic [COUNT_W-1:0]   count;
        logic                 stats;
        logic [SIZE_BITS-1:0] sizes   [MAX_SIZES];
        logic [COST_BITS-1:0] costs   [MAX_SIZES];
        logic                 cost_ok [MAX_SIZES];

        t_out_res pending_choices[$];
        int errors;
        int checked;
        int n_keep;
        int n_down;
        int n_cheaper;
        int n_above;
        int n_ack;

        function new();
            mode    = MODE_PAD_UP;
            pad_off = 1'b0;
            count   = '0;
            stats   = 1'b0;
            for (int i = 0; i < MAX_SIZES; i++) begin
                sizes[i]   = '0;
                costs[i]   = '0;
                cost_ok[i] = 1'b0;
            end
            errors    = 0;
            checked   = 0;
            n_keep    = 0;
            n_down    = 0;
            n_cheaper = 0;
            n_above   = 0;
            n_ack     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_POLICY_MODE:   mode    = d[MODE_W-1:0];
                REG_PADDING_OFF:   pad_off = d[0];
                REG_SIZE_COUNT:    count   = d[COUNT_W-1:0];
                REG_STATS_PRESENT: stats   = d[0];
                default: ;
            endcase
        endfunction

        // Applies a request to the table copy and returns the result the block should give.
        function t_out_res choose_size(t_in_req r);
            t_out_res               res;
            int                     n;
            int                     up_i;
            int                     dn_i;
            bit                     up_hit;
            bit                     dn_hit;
            longint unsigned        up_side;
            longint unsigned        dn_side;
            logic [SIZE_BITS-1:0]   cand;

            res = '0;
            if (r.cmd != CMD_DECIDE) begin
                if (r.cmd == CMD_WRITE_SIZE) begin
                    sizes[r.slot] = r.value[SIZE_BITS-1:0];
                end else if (r.cmd == CMD_WRITE_COST) begin
                    costs[r.slot]   = r.value[COST_BITS-1:0];
                    cost_ok[r.slot] = r.cost_known;
                end
                res.outcome = OUT_ACK;
                return res;
            end

            cand            = r.cand_size;
            res.chosen_size = cand;
            res.outcome     = OUT_KEEP;
            n = (count > MAX_SIZES) ? MAX_SIZES : int'(count);

            if (cand == 0 || mode == MODE_PAD_UP || mode == MODE_UNSUP ||
                (mode == MODE_MIN_COST && !stats) || pad_off || n == 0) begin
                return res;
            end

            // first entry from slot 0 at or above the candidate
            up_hit = 1'b0;
            up_i   = 0;
            for (int i = 0; i < n; i++) begin
                if (!up_hit && sizes[i] >= cand) begin
                    up_hit = 1'b1;
                    up_i   = i;
                end
            end
            if (!up_hit) begin
                res.above_largest = 1'b1;
                return res;
            end
            if (sizes[up_i] == cand) begin
                return res;
            end

            // last entry (scanning from the top) at or below the candidate
            dn_hit = 1'b0;
            dn_i   = 0;
            for (int i = n - 1; i >= 0; i--) begin
                if (!dn_hit && sizes[i] <= cand) begin
                    dn_hit = 1'b1;
                    dn_i   = i;
                end
            end
            if (!dn_hit || sizes[dn_i] == cand) begin
                return res;
            end

            if (mode == MODE_MIN_COST) begin
                if (!cost_ok[dn_i] || !cost_ok[up_i]) begin
                    return res;
                end
                // per-request cost, cross multiplied: up_cost/cand < dn_cost/dn_size
                up_side = 64'(costs[up_i]) * 64'(sizes[dn_i]);
                dn_side = 64'(costs[dn_i]) * 64'(cand);
                if (up_side < dn_side) begin
                    res.outcome = OUT_UP_CHEAPER;
                    return res;
                end
            end

            res.chosen_size = sizes[dn_i];
            res.outcome     = OUT_DOWN;
            return res;
        endfunction

        function void note_request(t_in_req r);
            pending_choices.push_back(choose_size(r));
        endfunction

        function int pending();
            return pending_choices.size();
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;

            if (pending_choices.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: size %0d outcome %0d above %0d",
                             got.chosen_size, got.outcome, got.above_largest);
                end
                return;
            end
            want = pending_choices.pop_front();
            checked++;
            case (want.outcome)
                OUT_ACK:        n_ack++;
                OUT_KEEP:       n_keep++;
                OUT_DOWN:       n_down++;
                OUT_UP_CHEAPER: n_cheaper++;
                default: ;
            endcase
            if (want.above_largest) begin
                n_above++;
            end
            if (got.chosen_size !== want.chosen_size || got.outcome !== want.outcome ||
                got.above_largest !== want.above_largest) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch on result %0d: expected size %0d outcome %0d above %0d,",
                             checked, want.chosen_size, want.outcome, want.above_largest);
                    $display("    got size %0d outcome %0d above %0d",
                             got.chosen_size, got.outcome, got.above_largest);
                end
            end
        endfunction

        function void flag_leftover();
            if (pending_choices.size() != 0) begin
                errors += pending_choices.size();
                $display("%0d expected results never arrived", pending_choices.size());
            end
        endfunction
    endclass

endpackage

>>> tb/sv/batch_size_padding_policy_test.sv
`timescale 1ns / 1ps
// Top of the self-checking testbench for batch_size_padding_policy.
module batch_size_padding_policy_test;

    import bsp_pkg::*;
    import bsp_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 14;
    localparam int MIXED_PER_PHASE = 105;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_req              in_data   = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    t_out_res             o_out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    bit            quiet      = 1'b0;
    int            cycles     = 0;
    int            stall_left = 0;
    int            n_sent     = 0;
    int            n_phases   = 0;
    policy_checker policy;

    batch_size_padding_policy dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL batch_size_padding_policy");
            $finish;
        end
    end

    // mostly short, a few long
    function automatic int stretch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 1;
        if (r < 85) return $urandom_range(2, 4);
        if (r < 97) return $urandom_range(5, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall  = 1'b1;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            stall_left = stretch() - 1;
            out_stall  = 1'b1;
        end else begin
            out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            policy.check_result(o_out_data);
        end
    end

    function automatic t_in_req make_req(logic [CMD_W-1:0] cmd, logic [15:0] cand,
                                         logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value,
                                         logic known);
        t_in_req r;
        r.cmd        = cmd;
        r.cand_size  = cand;
        r.slot       = slot;
        r.value      = value;
        r.cost_known = known;
        return r;
    endfunction

    task automatic send_req(input t_in_req r);
        int gap;
        gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : stretch();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        policy.note_request(r);
        n_sent++;
    endtask

    // waits until every result is back; config may only change then
    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (policy.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge i_clk);
        policy.set_reg(idx, d);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // candidates cluster on and around table entries
    function automatic logic [15:0] pick_cand();
        int r;
        int j;
        int c;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        j = $urandom_range(0, MAX_SIZES - 1);
        if (r < 5) return 16'd0;
        if (r < 9) return 16'hFFFF;
        if (r < 20) return 16'($urandom);
        if (r < 40) return policy.sizes[j];
        if (r < 55) begin
            c = int'(policy.sizes[j]) + $urandom_range(0, 6) - 3;
        end else begin
            lo = int'(policy.sizes[j]);
            hi = int'(policy.sizes[(j + 1) % MAX_SIZES]);
            c  = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
        end
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        return c[15:0];
    endfunction

    function automatic t_in_req mixed_req();
        int               r;
        int               s;
        int               near;
        logic [31:0]      cost;
        logic [31:0]      v;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, MAX_SIZES - 1);
        if (r < 78) begin
            return make_req(CMD_DECIDE, pick_cand(), 3'($urandom), $urandom, 1'($urandom));
        end
        if (r < 87) begin
            near = int'(policy.sizes[s]) + $urandom_range(0, 20) - 10;
            v    = $urandom_range(0, 1) ? {16'($urandom), 16'(near)} : $urandom;
            return make_req(CMD_WRITE_SIZE, 16'($urandom), 3'(s), v, 1'($urandom));
        end
        if (r < 96) begin
            cost = $urandom_range(0, 1) ? $urandom : policy.costs[s] + $urandom_range(0, 1000);
            return make_req(CMD_WRITE_COST, 16'($urandom), 3'(s), cost,
                            $urandom_range(0, 99) < 85);
        end
        return make_req(CMD_UNKNOWN, 16'($urandom), 3'($urandom), $urandom, 1'($urandom));
    endfunction

    // ascending sizes, costs roughly proportional to size with jitter
    task automatic load_table();
        int              v;
        int              step;
        int              rate;
        int              r;
        longint unsigned c;
        logic [31:0]     cost;
        v    = $urandom_range(1, 20);
        step = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 300) : $urandom_range(500, 8000);
        rate = $urandom_range(5, 1000);
        for (int s = 0; s < MAX_SIZES; s++) begin
            send_req(make_req(CMD_WRITE_SIZE, 16'($urandom), 3'(s),
                              {16'($urandom), 16'(v)}, 1'($urandom)));
            v += $urandom_range(1, step);
        end
        for (int s = 0; s < MAX_SIZES; s++) begin
            r = $urandom_range(0, 99);
            c = 64'(policy.sizes[s]) * 64'(rate) * 64'($urandom_range(70, 130)) / 100;
            if (r < 4) cost = '0;
            else if (r < 8) cost = '1;
            else cost = c[31:0];
            send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'(s), cost,
                              $urandom_range(0, 99) < 90));
        end
    endtask

    task automatic run_directed();
        logic [15:0] dir_sizes [MAX_SIZES];
        dir_sizes = '{16'd4, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128, 16'd1000, 16'd65535};

        // reset config: empty table, pad up
        send_req(make_req(CMD_DECIDE, 16'd0, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'hFFFF, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_UNKNOWN, 16'($urandom), 3'($urandom), $urandom, 1'($urandom)));
        for (int s = 0; s < MAX_SIZES; s++) begin
            send_req(make_req(CMD_WRITE_SIZE, 16'($urandom), 3'(s),
                              {(s == 0) ? 16'hFFFF : 16'h0000, dir_sizes[s]}, 1'($urandom)));
        end
        send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'd2, 32'd100, 1'b1));
        send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'd3, 32'd3200, 1'b1));
        send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'd4, 32'd4000, 1'b1));
        send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'd5, 32'hFFFF_FFFF, 1'b0));
        send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'd6, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(CMD_WRITE_COST, 16'($urandom), 3'd7, 32'd0, 1'b1));

        // batch down over the first seven entries
        drain();
        write_reg(REG_POLICY_MODE, {2'b00, MODE_BATCH_DOWN});
        write_reg(REG_SIZE_COUNT, 4'd7);
        send_req(make_req(CMD_DECIDE, 16'd50, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'd2000, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'd2, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'd16, 3'($urandom), $urandom, 1'($urandom)));

        // minimize cost: pad-up cheaper, unknown cost, zero cost, batch down
        drain();
        write_reg(REG_POLICY_MODE, {2'b00, MODE_MIN_COST});
        write_reg(REG_STATS_PRESENT, 4'd1);
        write_reg(REG_SIZE_COUNT, 4'd8);
        send_req(make_req(CMD_DECIDE, 16'd50, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'd100, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'd2000, 3'($urandom), $urandom, 1'($urandom)));
        send_req(make_req(CMD_DECIDE, 16'd20, 3'($urandom), $urandom, 1'($urandom)));
    endtask

    task automatic run_phase(input int p);
        logic [MODE_W-1:0]  mode;
        logic               pad;
        logic               stats;
        logic [COUNT_W-1:0] cnt;
        int                 r;
        drain();
        quiet = (p % 4 == 1);
        case (p)
            0: begin
                mode = MODE_MIN_COST;   pad = 1'b0; stats = 1'b1; cnt = 4'd8;
            end
            1: begin
                mode = MODE_BATCH_DOWN; pad = 1'b0; stats = 1'b1; cnt = 4'd15;
            end
            2: begin
                mode = MODE_MIN_COST;   pad = 1'b0; stats = 1'b1; cnt = 4'd1;
            end
            3: begin
                mode = MODE_UNSUP;      pad = 1'b1; stats = 1'b0; cnt = 4'd0;
            end
            default: begin
                r = $urandom_range(0, 99);
                if (r < 10) mode = MODE_PAD_UP;
                else if (r < 35) mode = MODE_BATCH_DOWN;
                else if (r < 92) mode = MODE_MIN_COST;
                else mode = MODE_UNSUP;
                pad   = ($urandom_range(0, 99) < 8);
                stats = ($urandom_range(0, 99) < 85);
                r = $urandom_range(0, 99);
                if (r < 8) cnt = 4'd0;
                else if (r < 45) cnt = 4'd8;
                else if (r < 80) cnt = 4'($urandom_range(1, 7));
                else cnt = 4'($urandom_range(9, 15));
            end
        endcase
        // unused upper data bits carry noise
        write_reg(REG_POLICY_MODE, {2'($urandom), mode});
        write_reg(REG_PADDING_OFF, {3'($urandom), pad});
        write_reg(REG_SIZE_COUNT, cnt);
        write_reg(REG_STATS_PRESENT, {3'($urandom), stats});
        n_phases++;
        load_table();
        for (int k = 0; k < MIXED_PER_PHASE; k++) begin
            send_req(mixed_req());
        end
    endtask

    initial begin
        policy = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            run_phase(p);
        end
        drain();
        repeat (20) @(posedge i_clk);
        policy.flag_leftover();

        $display("%0d requests over %0d random config phases, %0d results checked, %0d errors",
                 n_sent, n_phases, policy.checked, policy.errors);
        $display("outcomes: %0d kept (%0d above largest), %0d batched down,",
                 policy.n_keep, policy.n_above, policy.n_down);
        $display("    %0d pad-up cheaper, %0d acks", policy.n_cheaper, policy.n_ack);
        if (policy.errors == 0) begin
            $display("PASS batch_size_padding_policy");
        end else begin
            $display("FAIL batch_size_padding_policy");
        end
        $finish;
    end

endmodule
